/* src/jlvd_pkg.sv */
// Shared types and constants for the joint limit velocity damper.
package jlvd_pkg;

	localparam int ACTION_W   = 2;
	localparam int RHO_W      = 16;
	localparam int INV_W      = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RHO_MARGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_STEP   = 1'd1;

	localparam logic [RHO_W-1:0] RHO_HALF  = 16'd32768;
	localparam logic [RHO_W-1:0] RHO_RESET = 16'd3277;
	localparam logic [INV_W-1:0] INV_RESET = 32'd65536;

	typedef enum logic [ACTION_W-1:0] {
		ACT_BOTH  = 2'd0,
		ACT_LOWER = 2'd1,
		ACT_UPPER = 2'd2
	} action_t;

	// Source of one velocity limit at the output stage
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FULL,
		SEL_SCALED
	} rate_sel_t;

endpackage

/* src/joint_limit_velocity_damper.sv */
// Joint limit velocity damper: pipelined velocity bounds from position and limits.
//
//  channel   dir  handshake           payload
//  s_*       in   tvalid/tready       tuser: action; tdata: position, lower, upper
//  m_*       out  tvalid/tready       tdata: vel_up_limit, vel_down_limit
//  cfg_*     in   cfg_we              cfg_index, cfg_data (rho_margin, inv_step)
//
// One transaction per cycle while the output is not held. Five arithmetic
// stages, the scaling divider (one bit of v per stage) and the output register.
// Reset clears all valid bits and loads the register reset values.
// While a result waits at the output the pipe holds; the first stage still
// takes a transaction when it is empty.
module joint_limit_velocity_damper #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tuser: [1:0] action
	input  logic [jlvd_pkg::ACTION_W-1:0]       s_tuser,
	// tdata: position, lower_bound, upper_bound, zero pad
	input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: vel_up_limit, vel_down_limit, zero pad
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]  m_tdata,
	input  logic                                cfg_we,
	input  logic [jlvd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jlvd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jlvd_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int MW    = W + 1;
	localparam int HW    = (MW + 1) / 2;
	localparam int HIW   = MW - HW;
	localparam int RW    = MW + INV_W - FRAC_BITS;
	localparam int OUT_W = ((2*VALUE_WIDTH+7)/8)*8;

	// configuration
	logic [RHO_W-1:0] rho_q;
	logic [INV_W-1:0] inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rho_q <= RHO_RESET;
			inv_q <= INV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RHO_MARGIN: begin
					rho_q <= (cfg_data[RHO_W-1:0] > RHO_HALF) ? RHO_HALF : cfg_data[RHO_W-1:0];
				end
				REG_INV_STEP: begin
					inv_q <= cfg_data[INV_W-1:0];
				end
			endcase
		end
	end

	// flow control
	logic out_vld_q;
	logic en;
	logic ce1;
	logic vld_s1;

	assign en       = !out_vld_q || m_tready;
	assign ce1      = en || !vld_s1;
	assign s_tready = ce1;

	// stage 1: differences
	logic [W-1:0]          pos_in, lo_in, hi_in;
	logic [ACTION_W-1:0]   act_s1;
	logic signed [MW-1:0]  rng_s1, dlo_s1, dhi_s1;
	logic [W-1:0]          lo_s1, hi_s1;

	assign pos_in = s_tdata[W-1:0];
	assign lo_in  = s_tdata[2*W-1:W];
	assign hi_in  = s_tdata[3*W-1:2*W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce1) begin
			act_s1 <= s_tuser;
			rng_s1 <= $signed({hi_in[W-1], hi_in}) - $signed({lo_in[W-1], lo_in});
			dlo_s1 <= $signed({pos_in[W-1], pos_in}) - $signed({lo_in[W-1], lo_in});
			dhi_s1 <= $signed({hi_in[W-1], hi_in}) - $signed({pos_in[W-1], pos_in});
			lo_s1  <= lo_in;
			hi_s1  <= hi_in;
		end
	end

	// stage 2: magnitude of range or bound
	logic signed [MW-1:0] mag_src;
	logic                 neg_nx;
	logic                 vld_s2;
	logic [ACTION_W-1:0]  act_s2;
	logic [MW-1:0]        mag_s2;
	logic                 neg_s2;
	logic signed [MW-1:0] dlo_s2, dhi_s2;

	always_comb begin
		mag_src = '0;
		neg_nx  = 1'b0;
		unique case (action_t'(act_s1))
			ACT_BOTH: begin
				mag_src = rng_s1;
				neg_nx  = rng_s1[MW-1];
			end
			ACT_LOWER: mag_src = $signed({lo_s1[W-1], lo_s1});
			ACT_UPPER: mag_src = $signed({hi_s1[W-1], hi_s1});
			default:   mag_src = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			mag_s2 <= mag_src[MW-1] ? MW'(-mag_src) : MW'(mag_src);
			neg_s2 <= neg_nx;
			dlo_s2 <= dlo_s1;
			dhi_s2 <= dhi_s1;
		end
	end

	// stage 3: partial products of magnitude by inv_step and rho_margin
	logic                    vld_s3;
	logic [ACTION_W-1:0]     act_s3;
	logic                    neg_s3;
	logic signed [MW-1:0]    dlo_s3, dhi_s3;
	logic [HW+INV_W-1:0]     prl_s3;
	logic [HIW+INV_W-1:0]    prh_s3;
	logic [HW+RHO_W-1:0]     pdl_s3;
	logic [HIW+RHO_W-1:0]    pdh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3 <= act_s2;
			neg_s3 <= neg_s2;
			dlo_s3 <= dlo_s2;
			dhi_s3 <= dhi_s2;
			prl_s3 <= (HW+INV_W)'(mag_s2[HW-1:0]) * (HW+INV_W)'(inv_q);
			prh_s3 <= (HIW+INV_W)'(mag_s2[MW-1:HW]) * (HIW+INV_W)'(inv_q);
			pdl_s3 <= (HW+RHO_W)'(mag_s2[HW-1:0]) * (HW+RHO_W)'(rho_q);
			pdh_s3 <= (HIW+RHO_W)'(mag_s2[MW-1:HW]) * (HIW+RHO_W)'(rho_q);
		end
	end

	// stage 4: sum partial products, drop fraction
	logic [MW+INV_W-1:0] rate_sum;
	logic [MW+RHO_W-1:0] band_sum;
	logic                vld_s4;
	logic [ACTION_W-1:0] act_s4;
	logic                neg_s4;
	logic signed [MW-1:0] dlo_s4, dhi_s4;
	logic [RW-1:0]       rate_s4;
	logic [W-1:0]        band_s4;

	assign rate_sum = {prh_s3, {HW{1'b0}}} + (MW+INV_W)'(prl_s3);
	assign band_sum = {pdh_s3, {HW{1'b0}}} + (MW+RHO_W)'(pdl_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s4  <= act_s3;
			neg_s4  <= neg_s3;
			dlo_s4  <= dlo_s3;
			dhi_s4  <= dhi_s3;
			rate_s4 <= rate_sum[MW+INV_W-1:FRAC_BITS];
			// band width is at most half the magnitude, so it fits W bits
			band_s4 <= band_sum[FRAC_BITS+W-1:FRAC_BITS];
		end
	end

	// stage 5: saturate full rate, classify position
	logic          pos_ovf, neg_ovf;
	logic [W-1:0]  v_nx;
	logic          lo_out, hi_out, lo_band, hi_band;
	logic          use_hi;
	rate_sel_t     up_nx, dn_nx;
	logic          vld_s5;
	logic [W-1:0]  v_s5, num_s5, den_s5;
	rate_sel_t     up_s5, dn_s5;

	always_comb begin
		pos_ovf = |rate_s4[RW-1:W-1];
		neg_ovf = (|rate_s4[RW-1:W]) || (rate_s4[W-1] && (|rate_s4[W-2:0]));
		if (neg_s4) begin
			v_nx = neg_ovf ? {1'b1, {(W-1){1'b0}}} : W'(-rate_s4[W-1:0]);
		end else begin
			v_nx = pos_ovf ? {1'b0, {(W-1){1'b1}}} : rate_s4[W-1:0];
		end
	end

	always_comb begin
		lo_out  = dlo_s4[MW-1];
		hi_out  = dhi_s4[MW-1];
		lo_band = dlo_s4 < $signed({1'b0, band_s4});
		hi_band = dhi_s4 < $signed({1'b0, band_s4});
		use_hi  = 1'b0;
		up_nx   = SEL_ZERO;
		dn_nx   = SEL_ZERO;
		// test order: below lower, above upper, lower band, upper band, free
		unique case (action_t'(act_s4))
			ACT_BOTH: begin
				if (lo_out) begin
					up_nx = SEL_FULL;
				end else if (hi_out) begin
					dn_nx = SEL_FULL;
				end else if (lo_band) begin
					up_nx = SEL_FULL;
					dn_nx = SEL_SCALED;
				end else if (hi_band) begin
					up_nx  = SEL_SCALED;
					dn_nx  = SEL_FULL;
					use_hi = 1'b1;
				end else begin
					up_nx = SEL_FULL;
					dn_nx = SEL_FULL;
				end
			end
			ACT_LOWER: begin
				if (lo_out) begin
					dn_nx = SEL_ZERO;
				end else if (lo_band) begin
					dn_nx = SEL_SCALED;
				end else begin
					dn_nx = SEL_FULL;
				end
			end
			ACT_UPPER: begin
				use_hi = 1'b1;
				if (hi_out) begin
					up_nx = SEL_ZERO;
				end else if (hi_band) begin
					up_nx = SEL_SCALED;
				end else begin
					up_nx = SEL_FULL;
				end
			end
			default: begin
				up_nx = SEL_ZERO;
				dn_nx = SEL_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s5   <= v_nx;
			num_s5 <= use_hi ? dhi_s4[W-1:0] : dlo_s4[W-1:0];
			den_s5 <= band_s4;
			up_s5  <= up_nx;
			dn_s5  <= dn_nx;
		end
	end

	// divider: floor(v * num / den), one bit of v per stage, num < den
	logic          dv_vld_s6 [W];
	logic [W-1:0]  dv_rem_s6 [W];
	logic [W-1:0]  dv_quo_s6 [W];
	logic [W-1:0]  dv_num_s6 [W];
	logic [W-1:0]  dv_den_s6 [W];
	logic [W-1:0]  dv_v_s6   [W];
	rate_sel_t     dv_up_s6  [W];
	rate_sel_t     dv_dn_s6  [W];

	for (genvar k = 0; k < W; k++) begin : g_div
		logic         vld_in;
		logic [W-1:0] rem_in, quo_in, num_in, den_in, v_in;
		rate_sel_t    up_in, dn_in;
		logic [W+1:0] acc, den1, den2;
		logic [W-1:0] rem_nx, quo_nx;

		if (k == 0) begin : g_first
			assign vld_in = vld_s5;
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num_s5;
			assign den_in = den_s5;
			assign v_in   = v_s5;
			assign up_in  = up_s5;
			assign dn_in  = dn_s5;
		end else begin : g_next
			assign vld_in = dv_vld_s6[k-1];
			assign rem_in = dv_rem_s6[k-1];
			assign quo_in = dv_quo_s6[k-1];
			assign num_in = dv_num_s6[k-1];
			assign den_in = dv_den_s6[k-1];
			assign v_in   = dv_v_s6[k-1];
			assign up_in  = dv_up_s6[k-1];
			assign dn_in  = dv_dn_s6[k-1];
		end

		always_comb begin
			den1 = (W+2)'(den_in);
			den2 = {1'b0, den_in, 1'b0};
			acc  = {1'b0, rem_in, 1'b0} + (v_in[W-1-k] ? (W+2)'(num_in) : '0);
			// remainder stays below den, so at most two subtractions
			if (acc >= den2) begin
				rem_nx = W'(acc - den2);
				quo_nx = {quo_in[W-2:0], 1'b0} + W'(2);
			end else if (acc >= den1) begin
				rem_nx = W'(acc - den1);
				quo_nx = {quo_in[W-2:0], 1'b0} + W'(1);
			end else begin
				rem_nx = W'(acc);
				quo_nx = {quo_in[W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s6[k] <= 1'b0;
			end else if (en) begin
				dv_vld_s6[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s6[k] <= rem_nx;
				dv_quo_s6[k] <= quo_nx;
				dv_num_s6[k] <= num_in;
				dv_den_s6[k] <= den_in;
				dv_v_s6[k]   <= v_in;
				dv_up_s6[k]  <= up_in;
				dv_dn_s6[k]  <= dn_in;
			end
		end
	end

	// output register
	logic [W-1:0] up_nx_val, dn_nx_val;
	logic [W-1:0] up_q, dn_q;

	always_comb begin
		case (dv_up_s6[W-1])
			SEL_FULL:   up_nx_val = dv_v_s6[W-1];
			SEL_SCALED: up_nx_val = dv_quo_s6[W-1];
			default:    up_nx_val = '0;
		endcase
		case (dv_dn_s6[W-1])
			SEL_FULL:   dn_nx_val = dv_v_s6[W-1];
			SEL_SCALED: dn_nx_val = dv_quo_s6[W-1];
			default:    dn_nx_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s6[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_q <= up_nx_val;
			dn_q <= dn_nx_val;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'({dn_q, up_q});

endmodule

/* test/joint_limit_velocity_damper_test.sv */
// Self-checking stream testbench for the joint limit velocity damper.
`timescale 1ns / 1ps

module joint_limit_velocity_damper_test;
	import jlvd_pkg::*;

	localparam int VW = 32;
	localparam int IN_W = ((3 * VW + 7) / 8) * 8;
	localparam int OUT_W = ((2 * VW + 7) / 8) * 8;
	localparam int LATENCY = VW + 6;
	localparam int CLK_PERIOD = 10;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int IDLE_PCT = 24;
	localparam int PHASE_ITEMS = 100;
	localparam int STALL_AT = 150;
	localparam int STALL_CYCLES = 150;
	localparam longint Q_ONE = 65536;
	localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
	localparam longint VAL_MIN = -(longint'(1) <<< (VW - 1));
	localparam logic [95:0] RATE_POS_MAX = (96'd1 << (VW - 1)) - 1;
	localparam logic [95:0] RATE_NEG_MAG = 96'd1 << (VW - 1);
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VW-1:0]       position;
		logic [VW-1:0]       lower;
		logic [VW-1:0]       upper;
	} joint_sample_t;

	// same layout as m_tdata: vel_up_limit in the low bits
	typedef struct packed {
		logic [VW-1:0] vel_down;
		logic [VW-1:0] vel_up;
	} limits_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [ACTION_W-1:0]   s_tuser = '0;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [RHO_W-1:0] rho_cfg = RHO_RESET;
	logic [INV_W-1:0] inv_cfg = INV_RESET;

	joint_sample_t pending[$];
	limits_t       expected_limits[$];
	joint_sample_t offered;
	limits_t       got_limits;
	limits_t       want_limits;

	bit calm = 1'b0;
	bit sink_held_once = 1'b0;
	int sink_hold = 0;
	int results_checked = 0;
	int mismatches = 0;
	int input_stall_cycles = 0;
	int settings_run = 1;
	int mode_count[4] = '{0, 0, 0, 0};

	joint_limit_velocity_damper #(
		.VALUE_WIDTH(VW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clip_value(input longint x);
		if (x > VAL_MAX) return VAL_MAX;
		if (x < VAL_MIN) return VAL_MIN;
		return x;
	endfunction

	// sign(span) * floor(|span| * rho / 2^16)
	function automatic longint band_width(input longint span, input longint rho);
		longint mag;
		longint b;
		mag = (span < 0) ? -span : span;
		b = (mag * rho) >>> FRAC_BITS;
		return (span < 0) ? -b : b;
	endfunction

	// sign(span) * floor(|span| * inv / 2^16), saturated to the value range
	function automatic longint travel_rate(input longint span, input logic [INV_W-1:0] inv);
		logic [95:0] wide;
		wide = 96'((span < 0) ? -span : span);
		wide = (wide * inv) >> FRAC_BITS;
		if (span < 0) begin
			if (wide > RATE_NEG_MAG) wide = RATE_NEG_MAG;
			return -longint'(wide[63:0]);
		end
		if (wide > RATE_POS_MAX) wide = RATE_POS_MAX;
		return longint'(wide[63:0]);
	endfunction

	// sign(rate) * floor(|rate| * gap / den), zero outside 0 <= gap < den
	function automatic longint damped_rate(input longint rate, input longint gap,
			input longint den);
		logic [95:0] wide;
		longint q;
		if (gap < 0 || den <= 0 || gap >= den) return 0;
		wide = 96'((rate < 0) ? -rate : rate);
		wide = (wide * gap) / den;
		q = longint'(wide[63:0]);
		return (rate < 0) ? -q : q;
	endfunction

	function automatic limits_t predict_limits(input joint_sample_t smp,
			input logic [RHO_W-1:0] rho_reg, input logic [INV_W-1:0] inv_reg);
		limits_t lim;
		longint pos, lo, hi, rho, span, rate, band, mag, up, dn;
		pos = longint'($signed(smp.position));
		lo = longint'($signed(smp.lower));
		hi = longint'($signed(smp.upper));
		rho = longint'((rho_reg > RHO_HALF) ? RHO_HALF : rho_reg);
		up = 0;
		dn = 0;
		case (smp.action)
			ACT_BOTH: begin
				span = hi - lo;
				rate = travel_rate(span, inv_reg);
				band = band_width(span, rho);
				// crossed bounds always leave through one of the first two branches
				if (pos < lo) begin
					up = rate;
				end else if (pos > hi) begin
					dn = rate;
				end else if (pos < lo + band) begin
					up = rate;
					dn = damped_rate(rate, pos - lo, band);
				end else if (pos > hi - band) begin
					up = damped_rate(rate, hi - pos, band);
					dn = rate;
				end else begin
					up = rate;
					dn = rate;
				end
			end
			ACT_LOWER: begin
				mag = (lo < 0) ? -lo : lo;
				rate = travel_rate(mag, inv_reg);
				band = band_width(mag, rho);
				if (pos < lo) dn = 0;
				else if (pos < lo + band) dn = damped_rate(rate, pos - lo, band);
				else dn = rate;
			end
			ACT_UPPER: begin
				mag = (hi < 0) ? -hi : hi;
				rate = travel_rate(mag, inv_reg);
				band = band_width(mag, rho);
				if (pos > hi) up = 0;
				else if (pos > hi - band) up = damped_rate(rate, hi - pos, band);
				else up = rate;
			end
			default: begin
				up = 0;
				dn = 0;
			end
		endcase
		lim.vel_up = up[VW-1:0];
		lim.vel_down = dn[VW-1:0];
		return lim;
	endfunction

	// magnitude with a random bit length so that small and huge scales both show up
	function automatic longint random_magnitude();
		int unsigned nbits;
		logic [63:0] raw;
		nbits = $urandom_range(1, 32);
		raw = {$urandom, $urandom};
		return longint'(raw & ((64'd1 << nbits) - 1));
	endfunction

	function automatic joint_sample_t random_sample();
		joint_sample_t smp;
		longint lo, hi, band, pos, rho, spread;
		logic [63:0] raw;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) smp.action = ACT_UNUSED;
		else if (pick < 50) smp.action = ACT_BOTH;
		else if (pick < 75) smp.action = ACT_LOWER;
		else smp.action = ACT_UPPER;
		smp.position = $urandom;
		smp.lower = $urandom;
		smp.upper = $urandom;
		// leave some items fully random as noise
		if ($urandom_range(0, 99) < 15 || smp.action == ACT_UNUSED) return smp;
		rho = longint'((rho_cfg > RHO_HALF) ? RHO_HALF : rho_cfg);
		if (smp.action == ACT_BOTH) begin
			spread = random_magnitude();
			lo = longint'($signed(smp.lower));
			if (lo + spread > VAL_MAX) lo = clip_value(VAL_MAX - spread);
			hi = clip_value(lo + spread);
			band = band_width(hi - lo, rho);
		end else if (smp.action == ACT_LOWER) begin
			lo = random_magnitude();
			if ($urandom_range(0, 1) == 0) lo = -lo;
			lo = clip_value(lo);
			band = band_width((lo < 0) ? -lo : lo, rho);
			hi = clip_value(lo + band + random_magnitude());
		end else begin
			hi = random_magnitude();
			if ($urandom_range(0, 1) == 0) hi = -hi;
			hi = clip_value(hi);
			band = band_width((hi < 0) ? -hi : hi, rho);
			lo = clip_value(hi - band - random_magnitude());
		end
		// place the position around the bounds and the band edges
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: pos = lo - 1 - $urandom_range(0, 1 << 20);
			1: pos = lo + longint'(raw % (band + 1));
			2: pos = lo + band;
			3: pos = hi - longint'(raw % (band + 1));
			4: pos = hi - band;
			5: pos = hi + 1 + $urandom_range(0, 1 << 20);
			default: pos = lo + longint'(raw % (hi - lo + 1));
		endcase
		pos = clip_value(pos);
		if (smp.action == ACT_BOTH && $urandom_range(0, 9) == 0) begin
			spread = lo;
			lo = hi;
			hi = spread;
		end
		smp.position = pos[VW-1:0];
		smp.lower = lo[VW-1:0];
		smp.upper = hi[VW-1:0];
		return smp;
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		if (mismatches < 20)
			$display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic queue_sample(input logic [ACTION_W-1:0] act, input longint pos,
			input longint lo, input longint hi);
		joint_sample_t smp;
		smp.action = act;
		smp.position = pos[VW-1:0];
		smp.lower = lo[VW-1:0];
		smp.upper = hi[VW-1:0];
		pending.insert(pending.size(), smp);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		if (reg_index == REG_RHO_MARGIN) rho_cfg = value[RHO_W-1:0];
		else inv_cfg = value[INV_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending.size() != 0 || s_tvalid || expected_limits.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input logic [RHO_W-1:0] rho, input logic [INV_W-1:0] inv,
			input bit quiet);
		write_reg(REG_RHO_MARGIN, CFG_DATA_W'(rho));
		write_reg(REG_INV_STEP, CFG_DATA_W'(inv));
		@(negedge clk);
		calm = quiet;
		repeat (PHASE_ITEMS) pending.insert(pending.size(), random_sample());
		wait_drained();
		settings_run++;
	endtask

	// driver: predict on each accepted transaction, then offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= '0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && !s_tready) input_stall_cycles++;
			if (s_tvalid && s_tready) begin
				expected_limits.insert(expected_limits.size(),
					predict_limits(offered, rho_cfg, inv_cfg));
				mode_count[offered.action]++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					offered = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= offered.action;
					s_tdata <= IN_W'({offered.upper, offered.lower, offered.position});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transaction and throttle the output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_limits = m_tdata[2*VW-1:0];
				if (expected_limits.size() == 0) begin
					report_mismatch("result with none pending", got_limits.vel_up, '0);
				end else begin
					want_limits = expected_limits.pop_front();
					if (got_limits.vel_up !== want_limits.vel_up)
						report_mismatch("vel_up_limit", got_limits.vel_up, want_limits.vel_up);
					if (got_limits.vel_down !== want_limits.vel_down)
						report_mismatch("vel_down_limit", got_limits.vel_down,
							want_limits.vel_down);
				end
				results_checked <= results_checked + 1;
			end
			// one long hold-off so the pipe fills and stalls its input
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				m_tready <= 1'b0;
			end else if (!sink_held_once && results_checked >= STALL_AT) begin
				sink_held_once <= 1'b1;
				sink_hold <= STALL_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL joint_limit_velocity_damper");
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);
		// directed items at the reset register values
		queue_sample(ACT_BOTH, 15 * Q_ONE, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 10 * Q_ONE - 1, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 20 * Q_ONE + 1, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 10 * Q_ONE + 100, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 20 * Q_ONE - 100, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 10 * Q_ONE, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 20 * Q_ONE, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 10 * Q_ONE + 32770, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 20 * Q_ONE - 32770, 10 * Q_ONE, 20 * Q_ONE);
		queue_sample(ACT_BOTH, 0, VAL_MIN, VAL_MAX);
		queue_sample(ACT_BOTH, VAL_MIN, VAL_MIN, VAL_MAX);
		queue_sample(ACT_BOTH, VAL_MAX, VAL_MIN, VAL_MAX);
		// crossed and equal bounds, then the one-sided and unused actions
		queue_sample(ACT_BOTH, 15 * Q_ONE, 20 * Q_ONE, 10 * Q_ONE);
		queue_sample(ACT_BOTH, VAL_MIN, VAL_MAX, VAL_MIN);
		queue_sample(ACT_BOTH, VAL_MAX, 20 * Q_ONE, 10 * Q_ONE);
		queue_sample(ACT_BOTH, 10 * Q_ONE, 10 * Q_ONE, 10 * Q_ONE);
		queue_sample(ACT_BOTH, 0, 0, 0);
		queue_sample(ACT_LOWER, VAL_MAX, VAL_MIN, VAL_MIN);
		queue_sample(ACT_LOWER, 10 * Q_ONE + 10, 10 * Q_ONE, VAL_MAX);
		queue_sample(ACT_LOWER, -10 * Q_ONE - 1, -10 * Q_ONE, 0);
		queue_sample(ACT_LOWER, 0, 0, VAL_MIN);
		queue_sample(ACT_UPPER, VAL_MAX, VAL_MIN, VAL_MAX);
		queue_sample(ACT_UPPER, 20 * Q_ONE - 10, VAL_MAX, 20 * Q_ONE);
		queue_sample(ACT_UPPER, VAL_MIN, 0, VAL_MIN);
		queue_sample(ACT_UPPER, -20 * Q_ONE + 1, 0, -20 * Q_ONE);
		queue_sample(ACT_UNUSED, VAL_MAX, VAL_MIN, VAL_MAX);
		wait_drained();

		run_phase(16'd0, 32'd0, 1'b0);
		run_phase(RHO_HALF, 32'hFFFF_FFFF, 1'b0);
		run_phase(16'hFFFF, 32'd1, 1'b0);
		run_phase(16'd1, 32'h0004_0000, 1'b1);
		run_phase(RHO_W'($urandom_range(0, RHO_HALF)), $urandom, 1'b0);
		run_phase(RHO_W'($urandom_range(RHO_HALF + 1, 16'hFFFF)),
			INV_W'($urandom_range(0, Q_ONE)), 1'b0);
		run_phase(RHO_RESET, INV_RESET, 1'b0);

		// let any stray result surface
		repeat (LATENCY + 8) @(posedge clk);
		if (expected_limits.size() != 0)
			report_mismatch("results never delivered", VW'(expected_limits.size()), '0);

		$display("Checked %0d results over %0d register settings (modes %0d/%0d/%0d/%0d)",
			results_checked, settings_run, mode_count[ACT_BOTH], mode_count[ACT_LOWER],
			mode_count[ACT_UPPER], mode_count[ACT_UNUSED]);
		$display("Input back-pressured for %0d cycles, one output hold-off of %0d cycles",
			input_stall_cycles, STALL_CYCLES);
		if (mismatches == 0) begin
			$display("PASS joint_limit_velocity_damper");
		end else begin
			$display("FAIL joint_limit_velocity_damper");
		end
		$finish;
	end

endmodule
